// ----- hw/rtl/dmit_pkg.sv -----
package dmit_pkg;

  localparam int TAG_W = 32;
  localparam int ADDR_W = 32;
  localparam int CNT_W = 64;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int SHAMT_W = 3;
  localparam int RAW_IDX_W = 7;
  localparam int RAW_IDX_N = 1 << RAW_IDX_W;

  localparam logic [SHAMT_W-1:0] RESET_OFFSET_BITS = 3'd4;
  localparam logic [SHAMT_W-1:0] RESET_INDEX_BITS = 3'd2;
  localparam logic [ADDR_W-1:0] RESET_REGION_BASE = 32'hA000_0000;
  localparam logic [ADDR_W-1:0] RESET_REGION_SIZE = 32'h2000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 8'd0,
    CFG_INDEX_BITS  = 8'd1,
    CFG_REGION_BASE = 8'd2,
    CFG_REGION_SIZE = 8'd3
  } cfg_reg_t;

  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } line_t;

  typedef struct packed {
    logic  en;
    line_t line;
  } line_wr_t;

endpackage

// ----- hw/rtl/dmit_tag_ram.sv -----
module dmit_tag_ram #(
  parameter int LINE_SLOTS = 64,
  localparam int SlotW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [SlotW-1:0]     rd_slot,
  output dmit_pkg::line_t      rd_line,
  input  dmit_pkg::line_wr_t   wr,
  input  logic [SlotW-1:0]     wr_slot,
  output logic                 clearing
);

  dmit_pkg::line_t mem [LINE_SLOTS];
  logic [SlotW-1:0] clr_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_slot <= '0;
    end else if (clearing) begin
      if (clr_slot == SlotW'(LINE_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_slot <= clr_slot + 1'b1;
    end
  end

  // A write and a read of the same line in one cycle return the new line.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_slot] <= '0;
    end else if (wr.en) begin
      mem[wr_slot] <= wr.line;
    end
    if (rd_en) begin
      if (wr.en && wr_slot == rd_slot) begin
        rd_line <= wr.line;
      end else begin
        rd_line <= mem[rd_slot];
      end
    end
  end

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr.en && !rd_en)
    else $error("tag store accessed during clearing pass");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    clearing && clr_slot == SlotW'(LINE_SLOTS - 1) |=> !clearing)
    else $error("clearing pass did not end after the last line");

  a_clear_advances: assert property (@(posedge clk) disable iff (rst)
    clearing && !$past(rst) |-> clr_slot == $past(clr_slot) + 1'b1)
    else $error("clearing pass skipped a line");

endmodule

// ----- hw/rtl/direct_mapped_icache_hit_tracker_top.sv -----
// A fetch goes into stage s1 and its result into the output registers as s1 advances.
// Throughput: one fetch address per cycle while not stalled; the tag store has one read
// and one write port. Reset clears the counters, the pipeline and the configuration to
// its defaults. After reset the tag store is cleared one line per cycle, all LINE_SLOTS
// lines, while fetch_stall is held high; configuration writes are taken throughout.
module direct_mapped_icache_hit_tracker_top #(
  parameter int LINE_SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fetch_valid,
  output logic                                fetch_stall,
  input  logic [dmit_pkg::ADDR_W-1:0]         fetch_address,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                hit,
  output logic                                cacheable,
  output logic [dmit_pkg::CNT_W-1:0]          total_accesses,
  output logic [dmit_pkg::CNT_W-1:0]          hit_accesses,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmit_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmit_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SlotW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;

  logic [dmit_pkg::SHAMT_W-1:0] offset_bits;
  logic [dmit_pkg::SHAMT_W-1:0] index_bits;
  logic [dmit_pkg::ADDR_W-1:0]  region_base;
  logic [dmit_pkg::ADDR_W-1:0]  region_size;

  logic [SlotW-1:0] slot_lut [dmit_pkg::RAW_IDX_N];

  logic [dmit_pkg::ADDR_W:0]          region_end;
  logic                               in_region;
  logic [dmit_pkg::RAW_IDX_W:0]       idx_mask;
  logic [dmit_pkg::ADDR_W-1:0]        block_addr;
  logic [dmit_pkg::RAW_IDX_W-1:0]     raw_idx;
  logic [dmit_pkg::SHAMT_W:0]         tag_shift;
  dmit_pkg::tag_t                     fetch_tag;
  logic [SlotW-1:0]                   fetch_slot;
  logic                               accept;

  logic             s1_valid;
  logic             s1_cacheable;
  dmit_pkg::tag_t   s1_tag;
  logic [SlotW-1:0] s1_slot;
  logic             s1_adv;
  logic             s1_hit;

  dmit_pkg::line_t    rd_line;
  dmit_pkg::line_wr_t wr;
  logic               clearing;

  for (genvar gi = 0; gi < dmit_pkg::RAW_IDX_N; gi++) begin : g_slot_lut
    assign slot_lut[gi] = SlotW'(gi % LINE_SLOTS);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= dmit_pkg::RESET_OFFSET_BITS;
      index_bits  <= dmit_pkg::RESET_INDEX_BITS;
      region_base <= dmit_pkg::RESET_REGION_BASE;
      region_size <= dmit_pkg::RESET_REGION_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dmit_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data[dmit_pkg::SHAMT_W-1:0];
        dmit_pkg::CFG_INDEX_BITS:  index_bits <= cfg_data[dmit_pkg::SHAMT_W-1:0];
        dmit_pkg::CFG_REGION_BASE: region_base <= cfg_data;
        dmit_pkg::CFG_REGION_SIZE: region_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    region_end = {1'b0, region_base} + {1'b0, region_size};
    in_region  = (fetch_address >= region_base) && ({1'b0, fetch_address} < region_end);
    idx_mask   = (dmit_pkg::RAW_IDX_W + 1)'(1) << index_bits;
    idx_mask   = idx_mask - 1'b1;
    block_addr = fetch_address >> offset_bits;
    raw_idx    = block_addr[dmit_pkg::RAW_IDX_W-1:0] & idx_mask[dmit_pkg::RAW_IDX_W-1:0];
    tag_shift  = {1'b0, offset_bits} + {1'b0, index_bits};
    fetch_tag  = fetch_address >> tag_shift;
    fetch_slot = slot_lut[raw_idx];
  end

  assign s1_adv      = s1_valid && (!result_valid || !result_stall);
  assign fetch_stall = clearing || (s1_valid && !s1_adv);
  assign accept      = fetch_valid && !fetch_stall;
  assign s1_hit      = s1_cacheable && rd_line.valid && (rd_line.tag == s1_tag);

  assign wr.en         = s1_adv && s1_cacheable && !s1_hit;
  assign wr.line.valid = 1'b1;
  assign wr.line.tag   = s1_tag;

  dmit_tag_ram #(
    .LINE_SLOTS(LINE_SLOTS)
  ) u_tag_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_slot  (fetch_slot),
    .rd_line  (rd_line),
    .wr       (wr),
    .wr_slot  (s1_slot),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cacheable <= in_region;
      s1_tag       <= fetch_tag;
      s1_slot      <= fetch_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      total_accesses <= '0;
      hit_accesses   <= '0;
    end else if (s1_adv) begin
      result_valid   <= 1'b1;
      total_accesses <= total_accesses + 1'b1;
      hit_accesses   <= hit_accesses + dmit_pkg::CNT_W'(s1_hit);
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hit       <= s1_hit;
      cacheable <= s1_cacheable;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> fetch_stall)
    else $error("fetch accepted during clearing pass");

  a_hit_is_cacheable: assert property (@(posedge clk) disable iff (rst)
    result_valid && hit |-> cacheable)
    else $error("hit reported for a non-cacheable address");

  a_total_counts: assert property (@(posedge clk)
    !rst && s1_adv |=> rst || total_accesses == $past(total_accesses) + 1'b1)
    else $error("access counter did not advance with a result");

  a_hits_hold: assert property (@(posedge clk)
    !rst && !(s1_adv && s1_hit) |=> rst || $stable(hit_accesses))
    else $error("hit counter changed without a hit");

endmodule

// ----- tb/tb_direct_mapped_icache_hit_tracker_top.sv -----
module tb_direct_mapped_icache_hit_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 110;
  localparam logic [dmit_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd4;
  localparam logic [dmit_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

  typedef struct packed {
    logic                       hit;
    logic                       cacheable;
    logic [dmit_pkg::CNT_W-1:0] total;
    logic [dmit_pkg::CNT_W-1:0] hits;
  } lookup_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            fetch_valid = 1'b0;
  logic                            fetch_stall;
  logic [dmit_pkg::ADDR_W-1:0]     fetch_address = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic                            hit;
  logic                            cacheable;
  logic [dmit_pkg::CNT_W-1:0]      total_accesses;
  logic [dmit_pkg::CNT_W-1:0]      hit_accesses;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dmit_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dmit_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [dmit_pkg::SHAMT_W-1:0] cfg_offset = dmit_pkg::RESET_OFFSET_BITS;
  logic [dmit_pkg::SHAMT_W-1:0] cfg_index_bits = dmit_pkg::RESET_INDEX_BITS;
  logic [dmit_pkg::ADDR_W-1:0]  cfg_base = dmit_pkg::RESET_REGION_BASE;
  logic [dmit_pkg::ADDR_W-1:0]  cfg_size = dmit_pkg::RESET_REGION_SIZE;
  logic [dmit_pkg::TAG_W-1:0]   line_tag [SLOTS] = '{default: '0};
  logic                         line_ok [SLOTS] = '{default: 1'b0};
  logic [dmit_pkg::CNT_W-1:0]   access_count = '0;
  logic [dmit_pkg::CNT_W-1:0]   hit_tally = '0;

  lookup_t pending_lookups [$];
  int      errors = 0;
  int      cycle_count = 0;
  int      stall_cnt = 0;
  bit      idle_on = 1'b1;
  bit      fetch_held = 1'b0;

  direct_mapped_icache_hit_tracker_top #(
    .LINE_SLOTS(SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .fetch_valid(fetch_valid),
    .fetch_stall(fetch_stall),
    .fetch_address(fetch_address),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .hit(hit),
    .cacheable(cacheable),
    .total_accesses(total_accesses),
    .hit_accesses(hit_accesses),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    int n;
    if (stall_cnt != 0) begin
      stall_cnt = stall_cnt - 1;
    end else if (result_stall) begin
      result_stall <= 1'b0;
      stall_cnt = $urandom_range(0, 12);
    end else begin
      n = pick_gap();
      if (n != 0) begin
        result_stall <= 1'b1;
        stall_cnt = n - 1;
      end
    end
  end

  function automatic lookup_t predict_lookup(input logic [dmit_pkg::ADDR_W-1:0] a);
    lookup_t r;
    logic [dmit_pkg::ADDR_W:0] region_end;
    logic [dmit_pkg::ADDR_W-1:0] raw_index;
    int slot;
    int shift;
    logic [dmit_pkg::TAG_W-1:0] tag;
    region_end = {1'b0, cfg_base} + {1'b0, cfg_size};
    r.cacheable = (a >= cfg_base) && ({1'b0, a} < region_end);
    r.hit = 1'b0;
    access_count = access_count + 1;
    if (r.cacheable) begin
      raw_index = (a >> cfg_offset) & ((32'd1 << cfg_index_bits) - 32'd1);
      slot = int'(raw_index % SLOTS);
      shift = int'(cfg_offset) + int'(cfg_index_bits);
      tag = a >> shift;
      if (line_ok[slot] && line_tag[slot] == tag) begin
        r.hit = 1'b1;
        hit_tally = hit_tally + 1;
      end else begin
        line_tag[slot] = tag;
        line_ok[slot] = 1'b1;
      end
    end
    r.total = access_count;
    r.hits = hit_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: result transfer with no lookup outstanding", $time);
        errors = errors + 1;
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
          errors = errors + 1;
        end
        if (cacheable !== want.cacheable) begin
          $display("%0t: cacheable expected %0b actual %0b", $time, want.cacheable, cacheable);
          errors = errors + 1;
        end
        if (total_accesses !== want.total) begin
          $display("%0t: total_accesses expected %h actual %h", $time, want.total,
                   total_accesses);
          errors = errors + 1;
        end
        if (hit_accesses !== want.hits) begin
          $display("%0t: hit_accesses expected %h actual %h", $time, want.hits, hit_accesses);
          errors = errors + 1;
        end
      end
    end
  end

  task automatic send_fetch(input logic [dmit_pkg::ADDR_W-1:0] a);
    int gap;
    fetch_valid <= 1'b1;
    fetch_address <= a;
    fetch_held = 1'b1;
    @(posedge clk);
    while (fetch_stall) @(posedge clk);
    pending_lookups.push_back(predict_lookup(a));
    gap = pick_gap();
    if (gap != 0) begin
      fetch_valid <= 1'b0;
      fetch_address <= $urandom();
      fetch_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (fetch_held) begin
      fetch_valid <= 1'b0;
      fetch_held = 1'b0;
    end
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dmit_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dmit_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      dmit_pkg::CFG_OFFSET_BITS: cfg_offset = data[dmit_pkg::SHAMT_W-1:0];
      dmit_pkg::CFG_INDEX_BITS:  cfg_index_bits = data[dmit_pkg::SHAMT_W-1:0];
      dmit_pkg::CFG_REGION_BASE: cfg_base = data;
      dmit_pkg::CFG_REGION_SIZE: cfg_size = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_fetch(32'hA000_0000);
    send_fetch(32'hA000_0000);
    send_fetch(32'hA000_000C);
    send_fetch(32'h9FFF_FFFF);
    send_fetch(32'hBFFF_FFFF);
    send_fetch(32'hC000_0000);
    send_fetch(32'h0000_0000);
    send_fetch(32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_region_bounds();
    // The region end runs past the top of the address space here.
    write_reg(dmit_pkg::CFG_REGION_BASE, 32'hFFFF_FF00);
    write_reg(dmit_pkg::CFG_REGION_SIZE, 32'hFFFF_FFFF);
    send_fetch(32'hFFFF_FFFF);
    send_fetch(32'hFFFF_FEFF);
    wait_drained();
    write_reg(dmit_pkg::CFG_REGION_SIZE, 32'h0000_0000);
    send_fetch(32'hFFFF_FF00);
    wait_drained();
    write_reg(dmit_pkg::CFG_REGION_BASE, 32'hFFFF_FFFF);
    write_reg(dmit_pkg::CFG_REGION_SIZE, 32'h0000_0001);
    send_fetch(32'hFFFF_FFFF);
    send_fetch(32'hFFFF_FFFE);
    wait_drained();
    write_reg(dmit_pkg::CFG_REGION_BASE, 32'h0000_0000);
    write_reg(dmit_pkg::CFG_REGION_SIZE, 32'hFFFF_FFFF);
    send_fetch(32'h0000_0000);
    send_fetch(32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_narrow_offsets();
    write_reg(dmit_pkg::CFG_OFFSET_BITS, 32'h0000_0000);
    write_reg(dmit_pkg::CFG_INDEX_BITS, 32'h0000_0000);
    send_fetch(32'hFFFF_FFFE);
    send_fetch(32'hFFFF_FFFE);
    send_fetch(32'hFFFF_FFFD);
    wait_drained();
    write_reg(dmit_pkg::CFG_OFFSET_BITS, 32'hFFFF_FFF9);
    write_reg(dmit_pkg::CFG_INDEX_BITS, 32'h0000_0001);
    send_fetch(32'hFFFF_FFFC);
    wait_drained();
  endtask

  task automatic test_line_aliasing();
    // With 128 lines asked for, index 64 folds onto slot 0.
    write_reg(dmit_pkg::CFG_OFFSET_BITS, 32'h0000_0007);
    write_reg(dmit_pkg::CFG_INDEX_BITS, 32'h0000_0007);
    send_fetch(32'h0000_0000);
    send_fetch(32'h0000_2000);
    send_fetch(32'h0000_3F80);
    wait_drained();
  endtask

  task automatic test_geometry_change();
    write_reg(dmit_pkg::CFG_INDEX_BITS, 32'h0000_0003);
    send_fetch(32'h0000_2000);
    send_fetch(32'h0000_2000);
    wait_drained();
  endtask

  task automatic test_unknown_register();
    write_reg(CFG_UNUSED_LOW, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_HIGH, 32'h0000_0000);
    send_fetch(32'h0000_2000);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [dmit_pkg::ADDR_W-1:0] hot [16];
    logic [dmit_pkg::ADDR_W-1:0] span;
    logic [dmit_pkg::ADDR_W-1:0] a;
    int r;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      write_reg(dmit_pkg::CFG_OFFSET_BITS, $urandom());
      write_reg(dmit_pkg::CFG_INDEX_BITS, $urandom());
      case ($urandom_range(0, 4))
        0: begin
          write_reg(dmit_pkg::CFG_REGION_BASE, 32'h0000_0000);
          write_reg(dmit_pkg::CFG_REGION_SIZE, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(dmit_pkg::CFG_REGION_BASE, $urandom());
          write_reg(dmit_pkg::CFG_REGION_SIZE, $urandom_range(1, 32'h0001_0000));
        end
        2: begin
          write_reg(dmit_pkg::CFG_REGION_BASE, $urandom());
          write_reg(dmit_pkg::CFG_REGION_SIZE, $urandom());
        end
        3: begin
          write_reg(dmit_pkg::CFG_REGION_BASE, dmit_pkg::RESET_REGION_BASE);
          write_reg(dmit_pkg::CFG_REGION_SIZE, dmit_pkg::RESET_REGION_SIZE);
        end
        default: begin
          write_reg(dmit_pkg::CFG_REGION_BASE, $urandom());
          write_reg(dmit_pkg::CFG_REGION_SIZE, $urandom_range(0, 64));
        end
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      span = (cfg_size < 32'd4096) ? cfg_size : 32'd4096;
      foreach (hot[i]) hot[i] = (span != 0) ? cfg_base + ($urandom() % span) : $urandom();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          a = hot[$urandom_range(0, 15)];
        end else if (r < 80 && cfg_size != 0) begin
          a = cfg_base + ($urandom() % cfg_size);
        end else if (r < 88) begin
          case ($urandom_range(0, 3))
            0: a = cfg_base - 1;
            1: a = cfg_base;
            2: a = cfg_base + cfg_size - 1;
            default: a = cfg_base + cfg_size;
          endcase
        end else begin
          a = $urandom();
        end
        send_fetch(a);
      end
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_region_bounds();
    test_narrow_offsets();
    test_line_aliasing();
    test_geometry_change();
    test_unknown_register();
    test_random_traffic();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dmit_pkg.sv
hw/rtl/dmit_tag_ram.sv
hw/rtl/direct_mapped_icache_hit_tracker_top.sv
tb/tb_direct_mapped_icache_hit_tracker_top.sv
